>>> sv/esd_pkg.sv
package esd_pkg;

	localparam int NEURON_W  = 10;
	localparam int DOFF_W    = 4;
	localparam int SLOT_W    = 12;
	localparam int FAN_W     = 7;
	localparam int DATA_W    = 32;
	localparam int DECAY_W   = 16;
	localparam int KIND_W    = 3;
	localparam int SC_W      = 13;
	localparam int DSIU_W    = 5;
	localparam int OP_W      = DATA_W + 1;
	localparam int PROD_W    = 2 * OP_W;
	localparam int RUN_AW    = DOFF_W + NEURON_W;
	localparam int SYNAPSES  = 1 << SLOT_W;
	localparam int MAX_FANOUT = 64;
	localparam int CFG_IDX_W = 1;

	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SPIKE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ROUTE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STATE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELAY  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNAPSE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SLOTS   = 1'd1;

	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	function automatic logic [DATA_W-1:0] decay_sat(input prod_t p);
		logic [DATA_W-1:0] r;
		begin
			if (p[PROD_W-1:DATA_W+15] != '0) r = '1;
			else r = p[DATA_W+14:15];
			return r;
		end
	endfunction

	function automatic logic [DATA_W-1:0] current_sat(input prod_t p);
		logic [DATA_W-1:0] r;
		begin
			if (!p[PROD_W-1] && p[PROD_W-1:DATA_W+15] != '0)
				r = {1'b0, {(DATA_W-1){1'b1}}};
			else if (p[PROD_W-1] && p[PROD_W-1:DATA_W+15] != '1)
				r = {1'b1, {(DATA_W-1){1'b0}}};
			else
				r = p[DATA_W+15:16];
			return r;
		end
	endfunction

endpackage

>>> sv/esd_mul.sv
module esd_mul
	import esd_pkg::*;
(
	input  logic  clk,
	input  op_t   a,
	input  op_t   b,
	output prod_t p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

>>> sv/exp_synapse_spike_delivery_unit.sv
// Event-driven exponential synapse engine. One input transfer at a time: a table load
// (route, synapse state, delay entry) is written when taken; a tick reads, decays and
// writes back each entry below synapse_count (capped at SYNAPSES); a spike looks up its
// run, then per slot reads the route entry, bumps the trace (unless flagged) and
// forms the current, waiting while the output stalls. The steps are set by the single
// shared 33x33 multiplier and registered route and trace reads, once per slot or entry.
// Table contents are undefined until written; there is no clearing pass after reset.
module exp_synapse_spike_delivery_unit
	import esd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// neuron_id, delay_offset, synapse_slot, entry_index, target_neuron, start_slot,
	// fanout, gain, decay_factor, trace_value, zero fill
	input  logic [151:0]            s_axis_tdata,
	// kind
	input  logic [KIND_W-1:0]       s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// out_neuron, current_inc, zero fill
	output logic [47:0]             m_axis_tdata,
	// range_error
	output logic                    m_axis_tuser,
	output logic                    m_axis_tlast,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [SC_W-1:0]         cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RUN  = 4'd1;
	localparam logic [3:0] S_SLOT = 4'd2;
	localparam logic [3:0] S_ENT  = 4'd3;
	localparam logic [3:0] S_INC  = 4'd4;
	localparam logic [3:0] S_PRD  = 4'd5;
	localparam logic [3:0] S_TRD  = 4'd6;
	localparam logic [3:0] S_TMUL = 4'd7;
	localparam logic [3:0] S_TWB  = 4'd8;

	logic [NEURON_W-1:0] in_nid;
	logic [DOFF_W-1:0]   in_doff;
	logic [SLOT_W-1:0]   in_slot;
	logic [SLOT_W-1:0]   in_entry;
	logic [NEURON_W-1:0] in_tgt;
	logic [SLOT_W-1:0]   in_start;
	logic [FAN_W-1:0]    in_fan;
	logic [DATA_W-1:0]   in_gain;
	logic [DECAY_W-1:0]  in_dec;
	logic [DATA_W-1:0]   in_tv;

	assign in_nid   = s_axis_tdata[9:0];
	assign in_doff  = s_axis_tdata[13:10];
	assign in_slot  = s_axis_tdata[25:14];
	assign in_entry = s_axis_tdata[37:26];
	assign in_tgt   = s_axis_tdata[47:38];
	assign in_start = s_axis_tdata[59:48];
	assign in_fan   = s_axis_tdata[66:60];
	assign in_gain  = s_axis_tdata[98:67];
	assign in_dec   = s_axis_tdata[114:99];
	assign in_tv    = s_axis_tdata[146:115];

	logic [3:0]          state_q;
	logic [SC_W-1:0]     sc_q;
	logic [DSIU_W-1:0]   dsiu_q;
	logic [SC_W-1:0]     sid_q;
	logic [FAN_W-1:0]    cnt_q;
	logic [SC_W-1:0]     idx_q;
	logic [SLOT_W-1:0]   ent_q;
	logic                ok_q;
	logic [NEURON_W-1:0] tgt_q;
	logic [DATA_W-1:0]   inc_q;

	logic                out_valid_q;
	logic [NEURON_W-1:0] out_neuron_q;
	logic [DATA_W-1:0]   out_cur_q;
	logic                out_err_q;
	logic                out_last_q;

	logic [SLOT_W-1:0]   run_start_mem [1<<RUN_AW];
	logic [FAN_W-1:0]    run_len_mem   [1<<RUN_AW];
	logic [SLOT_W-1:0]   map_mem       [SYNAPSES];
	logic [NEURON_W-1:0] tgt_mem       [SYNAPSES];
	logic [DATA_W-1:0]   trace_mem     [SYNAPSES];
	logic [DATA_W-1:0]   gain_mem      [SYNAPSES];
	logic [DECAY_W-1:0]  decay_mem     [SYNAPSES];

	logic [SLOT_W-1:0]   run_start_rd;
	logic [FAN_W-1:0]    run_len_rd;
	logic [SLOT_W-1:0]   map_rd;
	logic [NEURON_W-1:0] tgt_rd;
	logic [DATA_W-1:0]   trace_rd;
	logic [DATA_W-1:0]   gain_rd;
	logic [DECAY_W-1:0]  decay_rd;

	logic                in_acc;
	logic                out_free;
	logic [SLOT_W-1:0]   tr_raddr;
	logic                tr_we;
	logic [SLOT_W-1:0]   tr_waddr;
	logic [DATA_W-1:0]   tr_wdata;
	logic [DATA_W:0]     inc_sum;
	logic [DATA_W-1:0]   inc_t;
	logic [SC_W-1:0]     tick_n;
	logic [FAN_W-1:0]    len_cut;
	op_t                 mul_a;
	op_t                 mul_b;
	prod_t               prod;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign inc_sum = {1'b0, trace_rd} + (DATA_W+1)'(32'h0001_0000);
	assign inc_t   = inc_sum[DATA_W] ? '1 : inc_sum[DATA_W-1:0];
	assign tick_n  = (sc_q > SC_W'(SYNAPSES)) ? SC_W'(SYNAPSES) : sc_q;
	assign len_cut = (run_len_rd > FAN_W'(MAX_FANOUT)) ? FAN_W'(MAX_FANOUT) : run_len_rd;
	assign tr_raddr = (state_q == S_ENT) ? map_rd : idx_q[SLOT_W-1:0];

	always_comb begin
		tr_we    = 1'b0;
		tr_waddr = idx_q[SLOT_W-1:0];
		tr_wdata = decay_sat(prod);
		mul_a    = {1'b0, trace_rd};
		mul_b    = {{(OP_W-DECAY_W){1'b0}}, decay_rd};
		unique case (state_q)
			S_IDLE: begin
				tr_we    = in_acc && s_axis_tuser == KIND_STATE;
				tr_waddr = in_entry;
				tr_wdata = in_tv;
			end
			S_INC: begin
				tr_we    = 1'b1;
				tr_waddr = ent_q;
				tr_wdata = inc_t;
				mul_a    = {gain_rd[DATA_W-1], gain_rd};
				mul_b    = {1'b0, inc_t};
			end
			S_PRD: begin
				mul_a    = {gain_rd[DATA_W-1], gain_rd};
				mul_b    = {1'b0, inc_q};
			end
			S_TWB: tr_we = 1'b1;
			default: ;
		endcase
	end

	esd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod)
	);

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == KIND_DELAY) begin
			run_start_mem[{in_doff, in_nid}] <= in_start;
			run_len_mem[{in_doff, in_nid}]   <= in_fan;
		end
		run_start_rd <= run_start_mem[{in_doff, in_nid}];
		run_len_rd   <= run_len_mem[{in_doff, in_nid}];
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == KIND_ROUTE) begin
			map_mem[in_slot] <= in_entry;
			tgt_mem[in_slot] <= in_tgt;
		end
		map_rd <= map_mem[sid_q[SLOT_W-1:0]];
		tgt_rd <= tgt_mem[sid_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tr_we) trace_mem[tr_waddr] <= tr_wdata;
		trace_rd <= trace_mem[tr_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == KIND_STATE) begin
			gain_mem[in_entry]  <= in_gain;
			decay_mem[in_entry] <= in_dec;
		end
		gain_rd  <= gain_mem[map_rd];
		decay_rd <= decay_mem[idx_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			dsiu_q <= DSIU_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNAPSE_COUNT: sc_q   <= cfg_data;
				CFG_DELAY_SLOTS:   dsiu_q <= cfg_data[DSIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ENT) begin
			ent_q <= map_rd;
			tgt_q <= tgt_rd;
			ok_q  <= sid_q < sc_q && sid_q < SC_W'(SYNAPSES);
		end
		if (state_q == S_INC) inc_q <= inc_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sid_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && s_axis_tuser == KIND_SPIKE
							&& {1'b0, in_doff} < dsiu_q) begin
						state_q <= S_RUN;
					end else if (in_acc && s_axis_tuser == KIND_TICK && tick_n != '0) begin
						idx_q   <= '0;
						state_q <= S_TRD;
					end
				end
				S_RUN: begin
					sid_q   <= {1'b0, run_start_rd};
					cnt_q   <= len_cut;
					state_q <= (len_cut == '0) ? S_IDLE : S_SLOT;
				end
				S_SLOT: state_q <= S_ENT;
				S_ENT: state_q <= (sid_q < sc_q && sid_q < SC_W'(SYNAPSES)) ? S_INC : S_PRD;
				S_INC: state_q <= S_PRD;
				S_PRD: begin
					if (out_free) begin
						if (cnt_q == FAN_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q - FAN_W'(1);
							sid_q   <= sid_q + SC_W'(1);
							state_q <= S_SLOT;
						end
					end
				end
				S_TRD: state_q <= S_TMUL;
				S_TMUL: state_q <= S_TWB;
				S_TWB: begin
					idx_q   <= idx_q + SC_W'(1);
					state_q <= (idx_q + SC_W'(1) >= tick_n) ? S_IDLE : S_TRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PRD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PRD && out_free) begin
			out_err_q    <= !ok_q;
			out_neuron_q <= ok_q ? tgt_q : '0;
			out_cur_q    <= ok_q ? current_sat(prod) : '0;
			out_last_q   <= (cnt_q == FAN_W'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_cur_q, out_neuron_q};
	assign m_axis_tuser  = out_err_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/esd_checker.sv
module esd_props
	import esd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [KIND_W-1:0]    s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [47:0]          m_axis_tdata,
	input logic                 m_axis_tuser,
	input logic                 m_axis_tlast
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("flagged result carries nonzero data");

	a_hs_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake output unknown after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind exp_synapse_spike_delivery_unit esd_props u_esd_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
